@@ rtl/qsfe_pkg.sv @@
// Package for the quad shape function unit: widths, codes and the queued item type.
`default_nettype none
package qsfe_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COORD_W   = 16;
    localparam int VAL_W     = 16;
    localparam int NODE_W    = 3;
    localparam int NC_W      = 4;
    localparam int MAX_NODES = 8;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    // operand widths: linear factors, quadratic factors, products
    localparam int LIN_W = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
    localparam int SQ_W  = ((2 * FRAC_BITS > 30) ? 2 * FRAC_BITS : 30) + 2;
    localparam int P1_W  = SQ_W + LIN_W;
    localparam int P2_W  = (P1_W > 3 * LIN_W) ? P1_W : 3 * LIN_W;
    localparam int M_W   = P2_W + 2;
    localparam int SH_W  = $clog2(2 * FRAC_BITS + 3);

    // final right shifts, power-of-two weights already folded in
    localparam logic [SH_W-1:0] SH_E2    = SH_W'(2);
    localparam logic [SH_W-1:0] SH_E1    = SH_W'(FRAC_BITS + 2);
    localparam logic [SH_W-1:0] SH_E1_K2 = SH_W'(FRAC_BITS + 1);
    localparam logic [SH_W-1:0] SH_E1_K4 = SH_W'(FRAC_BITS);
    localparam logic [SH_W-1:0] SH_E0    = SH_W'(2 * FRAC_BITS + 2);
    localparam logic [SH_W-1:0] SH_E0_K2 = SH_W'(2 * FRAC_BITS + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [NC_W-1:0] NC_BILIN = NC_W'(4);
    localparam logic [NC_W-1:0] NC_SEREN = NC_W'(8);
    localparam logic [NC_W-1:0] NC_RESET = NC_BILIN;

    localparam logic CMD_VALUE = 1'b0;
    localparam logic CMD_DERIV = 1'b1;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_BILIN,
        MODE_SEREN
    } mode_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] xi;
        logic signed [COORD_W-1:0] eta;
        logic signed [SQ_W-1:0]    cx;     // s^2 - xi^2
        logic signed [SQ_W-1:0]    cy;     // s^2 - eta^2
        logic                      cmd;
        mode_t                     mode;
        logic [CNT_W-1:0]          count;  // result words for this item
    } item_t;

endpackage
`default_nettype wire

@@ rtl/qsfe_front.sv @@
// Front end: classifies an incoming word by node count and forms the quadratic terms.
`default_nettype none
module qsfe_front (
    input  wire logic [qsfe_pkg::NC_W-1:0]           node_count,
    input  wire logic signed [qsfe_pkg::COORD_W-1:0] xi_coord,
    input  wire logic signed [qsfe_pkg::COORD_W-1:0] eta_coord,
    input  wire logic                                command,
    output qsfe_pkg::item_t                          item
);
    import qsfe_pkg::*;

    localparam logic signed [SQ_W-1:0] S_SQ = SQ_W'(1) <<< (2 * FRAC_BITS);

    logic signed [2*COORD_W-1:0] xx;
    logic signed [2*COORD_W-1:0] yy;

    assign xx = xi_coord * xi_coord;
    assign yy = eta_coord * eta_coord;

    always_comb begin
        item.xi  = xi_coord;
        item.eta = eta_coord;
        item.cx  = S_SQ - SQ_W'(xx);
        item.cy  = S_SQ - SQ_W'(yy);
        item.cmd = command;
        if (node_count == NC_BILIN) begin
            item.mode = MODE_BILIN;
        end else if (node_count == NC_SEREN) begin
            item.mode = MODE_SEREN;
        end else begin
            item.mode = MODE_ZERO;
        end
        if (node_count > NC_W'(MAX_NODES)) begin
            item.count = CNT_W'(MAX_NODES);
        end else begin
            item.count = CNT_W'(node_count);
        end
    end

endmodule
`default_nettype wire

@@ rtl/qsfe_queue.sv @@
// Small FIFO of classified items between the front end and the evaluation pipeline.
`default_nettype none
module qsfe_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire qsfe_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output qsfe_pkg::item_t      head_item,
    output logic                 head_valid
);
    import qsfe_pkg::*;

    item_t                slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/qsfe_back.sv @@
// Back end: evaluates head item nodes in a pipeline, one per cycle unless m_ready stalls.
`default_nettype none
module qsfe_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire qsfe_pkg::item_t                   head_item,
    input  wire logic                              head_valid,
    output logic                                   pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [qsfe_pkg::NODE_W-1:0]            m_node_index,
    output logic signed [qsfe_pkg::VAL_W-1:0]      m_first_value,
    output logic signed [qsfe_pkg::VAL_W-1:0]      m_second_value,
    output logic                                   m_last_node
);
    import qsfe_pkg::*;

    typedef struct packed {
        logic signed [SQ_W-1:0]  a;
        logic signed [LIN_W-1:0] b;
        logic                    neg;
        logic                    zero;
        logic [SH_W-1:0]         sh;
    } op_t;

    typedef struct packed {
        logic            neg;
        logic            zero;
        logic [SH_W-1:0] sh;
    } lane_ctl_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
    } tag_t;

    localparam logic signed [LIN_W-1:0] S_LIN   = LIN_W'(1) <<< FRAC_BITS;
    localparam logic signed [LIN_W-1:0] B_ONE   = LIN_W'(1);
    localparam logic signed [M_W-1:0]   SAT_MAX = M_W'((1 << (VAL_W - 1)) - 1);
    localparam logic signed [M_W-1:0]   SAT_MIN = -M_W'(1 << (VAL_W - 1));
    localparam op_t                     ZERO_OP = '{a: '0, b: '0, neg: 1'b0,
                                                    zero: 1'b1, sh: SH_E2};

    function automatic op_t mk_op(input logic signed [SQ_W-1:0]  a,
                                  input logic signed [LIN_W-1:0] b,
                                  input logic                    neg,
                                  input logic [SH_W-1:0]         sh);
        op_t o;
        o.a    = a;
        o.b    = b;
        o.neg  = neg;
        o.zero = 1'b0;
        o.sh   = sh;
        return o;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [M_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_MAX) begin
            r = VAL_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r = VAL_W'(SAT_MIN);
        end else begin
            r = VAL_W'(v);
        end
        return r;
    endfunction

    function automatic lane_ctl_t ctl_of(input op_t o);
        lane_ctl_t c;
        c.neg  = o.neg;
        c.zero = o.zero;
        c.sh   = o.sh;
        return c;
    endfunction

    // ---------------- node sequencer ----------------
    logic              en;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              issue;
    logic              is_last;

    assign en      = !m_valid || m_ready;
    assign is_last = ({1'b0, node_reg} == (head_item.count - 1'b1));
    assign issue   = en && head_valid && (head_item.count != '0);
    assign pop     = en && head_valid && ((head_item.count == '0) || is_last);

    always_comb begin
        node_next = node_reg;
        if (issue) begin
            node_next = is_last ? '0 : node_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg <= '0;
        end else begin
            node_reg <= node_next;
        end
    end

    // ---------------- operand select ----------------
    logic signed [LIN_W-1:0] xs, ys, xm, xp, ym, yp;
    logic signed [LIN_W-1:0] lin0, lin1, lin2, lin3;
    logic signed [LIN_W-1:0] d2xpy, d2xmy, dxp2y, d2ymx;
    logic signed [SQ_W-1:0]  a_xm, a_xp, a_ym, a_yp, a_x, a_y;
    op_t                     f_op, g_op;
    logic signed [LIN_W-1:0] f_c;
    logic                    f_use_c;

    always_comb begin
        xs    = LIN_W'(head_item.xi);
        ys    = LIN_W'(head_item.eta);
        xm    = S_LIN - xs;
        xp    = S_LIN + xs;
        ym    = S_LIN - ys;
        yp    = S_LIN + ys;
        lin0  = -xs - ys - S_LIN;
        lin1  = xs - ys - S_LIN;
        lin2  = xs + ys - S_LIN;
        lin3  = ys - xs - S_LIN;
        d2xpy = (xs <<< 1) + ys;
        d2xmy = (xs <<< 1) - ys;
        dxp2y = xs + (ys <<< 1);
        d2ymx = (ys <<< 1) - xs;
        a_xm  = SQ_W'(xm);
        a_xp  = SQ_W'(xp);
        a_ym  = SQ_W'(ym);
        a_yp  = SQ_W'(yp);
        a_x   = SQ_W'(xs);
        a_y   = SQ_W'(ys);
    end

    always_comb begin
        f_op    = ZERO_OP;
        g_op    = ZERO_OP;
        f_c     = B_ONE;
        f_use_c = 1'b0;
        unique case (head_item.mode)
            MODE_BILIN: begin
                if (head_item.cmd == CMD_VALUE) begin
                    unique case (node_reg)
                        3'd0:    f_op = mk_op(a_xm, ym, 1'b0, SH_E1);
                        3'd1:    f_op = mk_op(a_xp, ym, 1'b0, SH_E1);
                        3'd2:    f_op = mk_op(a_xp, yp, 1'b0, SH_E1);
                        3'd3:    f_op = mk_op(a_xm, yp, 1'b0, SH_E1);
                        default: f_op = ZERO_OP;
                    endcase
                end else begin
                    unique case (node_reg)
                        3'd0: begin
                            f_op = mk_op(a_ym, B_ONE, 1'b1, SH_E2);
                            g_op = mk_op(a_xm, B_ONE, 1'b1, SH_E2);
                        end
                        3'd1: begin
                            f_op = mk_op(a_ym, B_ONE, 1'b0, SH_E2);
                            g_op = mk_op(a_xp, B_ONE, 1'b1, SH_E2);
                        end
                        3'd2: begin
                            f_op = mk_op(a_yp, B_ONE, 1'b0, SH_E2);
                            g_op = mk_op(a_xp, B_ONE, 1'b0, SH_E2);
                        end
                        3'd3: begin
                            f_op = mk_op(a_yp, B_ONE, 1'b1, SH_E2);
                            g_op = mk_op(a_xm, B_ONE, 1'b0, SH_E2);
                        end
                        default: begin
                            f_op = ZERO_OP;
                            g_op = ZERO_OP;
                        end
                    endcase
                end
            end
            MODE_SEREN: begin
                if (head_item.cmd == CMD_VALUE) begin
                    // corners need a third factor, taken by the second multiplier
                    unique case (node_reg)
                        3'd0: begin
                            f_op = mk_op(a_xm, ym, 1'b0, SH_E0);
                            f_c = lin0;
                            f_use_c = 1'b1;
                        end
                        3'd1: begin
                            f_op = mk_op(a_xp, ym, 1'b0, SH_E0);
                            f_c = lin1;
                            f_use_c = 1'b1;
                        end
                        3'd2: begin
                            f_op = mk_op(a_xp, yp, 1'b0, SH_E0);
                            f_c = lin2;
                            f_use_c = 1'b1;
                        end
                        3'd3: begin
                            f_op = mk_op(a_xm, yp, 1'b0, SH_E0);
                            f_c = lin3;
                            f_use_c = 1'b1;
                        end
                        3'd4:    f_op = mk_op(head_item.cx, ym, 1'b0, SH_E0_K2);
                        3'd5:    f_op = mk_op(head_item.cy, xp, 1'b0, SH_E0_K2);
                        3'd6:    f_op = mk_op(head_item.cx, yp, 1'b0, SH_E0_K2);
                        default: f_op = mk_op(head_item.cy, xm, 1'b0, SH_E0_K2);
                    endcase
                end else begin
                    unique case (node_reg)
                        3'd0: begin
                            f_op = mk_op(a_ym, d2xpy, 1'b0, SH_E1);
                            g_op = mk_op(a_xm, dxp2y, 1'b0, SH_E1);
                        end
                        3'd1: begin
                            f_op = mk_op(a_ym, d2xmy, 1'b0, SH_E1);
                            g_op = mk_op(a_xp, d2ymx, 1'b0, SH_E1);
                        end
                        3'd2: begin
                            f_op = mk_op(a_yp, d2xpy, 1'b0, SH_E1);
                            g_op = mk_op(a_xp, dxp2y, 1'b0, SH_E1);
                        end
                        3'd3: begin
                            f_op = mk_op(a_yp, d2xmy, 1'b0, SH_E1);
                            g_op = mk_op(a_xm, d2ymx, 1'b0, SH_E1);
                        end
                        3'd4: begin
                            f_op = mk_op(a_x, ym, 1'b1, SH_E1_K4);
                            g_op = mk_op(head_item.cx, B_ONE, 1'b1, SH_E1_K2);
                        end
                        3'd5: begin
                            f_op = mk_op(head_item.cy, B_ONE, 1'b0, SH_E1_K2);
                            g_op = mk_op(a_y, xp, 1'b1, SH_E1_K4);
                        end
                        3'd6: begin
                            f_op = mk_op(a_x, yp, 1'b1, SH_E1_K4);
                            g_op = mk_op(head_item.cx, B_ONE, 1'b0, SH_E1_K2);
                        end
                        default: begin
                            f_op = mk_op(head_item.cy, B_ONE, 1'b1, SH_E1_K2);
                            g_op = mk_op(a_y, xm, 1'b1, SH_E1_K4);
                        end
                    endcase
                end
            end
            default: begin
                f_op = ZERO_OP;
                g_op = ZERO_OP;
            end
        endcase
    end

    // ---------------- pipeline ----------------
    // S1 operands, S2 first product, S3 full product, S4 signed and rounded, out
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                    out_valid_reg;
    op_t                     s1_f_reg, s1_g_reg;
    logic signed [LIN_W-1:0] s1_c_reg, s2_c_reg;
    logic                    s1_use_c_reg, s2_use_c_reg;
    tag_t                    s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, out_tag_reg;
    lane_ctl_t               s2_fctl_reg, s2_gctl_reg, s3_fctl_reg, s3_gctl_reg;
    logic signed [P1_W-1:0]  s2_fp_reg, s2_gp_reg, s2_fp_next, s2_gp_next;
    logic signed [P2_W-1:0]  s3_fp_reg, s3_gp_reg, s3_fp_next, s3_gp_next;
    logic signed [M_W-1:0]   s4_fm_reg, s4_gm_reg, s4_fm_next, s4_gm_next;
    logic [SH_W-1:0]         s4_fsh_reg, s4_gsh_reg;
    logic signed [VAL_W-1:0] out_first_reg, out_second_reg;
    logic signed [VAL_W-1:0] out_first_next, out_second_next;
    logic signed [2*LIN_W-1:0] fp_lo;
    tag_t                    tag_next;

    assign tag_next.node = node_reg;
    assign tag_next.last = is_last;

    assign s2_fp_next = P1_W'(s1_f_reg.a) * P1_W'(s1_f_reg.b);
    assign s2_gp_next = P1_W'(s1_g_reg.a) * P1_W'(s1_g_reg.b);

    assign fp_lo      = s2_fp_reg[2*LIN_W-1:0];
    assign s3_fp_next = s2_use_c_reg ? P2_W'(fp_lo) * P2_W'(s2_c_reg) : P2_W'(s2_fp_reg);
    assign s3_gp_next = P2_W'(s2_gp_reg);

    always_comb begin
        if (s3_fctl_reg.zero) begin
            s4_fm_next = '0;
        end else begin
            s4_fm_next = (s3_fctl_reg.neg ? -M_W'(s3_fp_reg) : M_W'(s3_fp_reg))
                       + (M_W'(1) <<< (s3_fctl_reg.sh - 1'b1));
        end
        if (s3_gctl_reg.zero) begin
            s4_gm_next = '0;
        end else begin
            s4_gm_next = (s3_gctl_reg.neg ? -M_W'(s3_gp_reg) : M_W'(s3_gp_reg))
                       + (M_W'(1) <<< (s3_gctl_reg.sh - 1'b1));
        end
    end

    assign out_first_next  = sat_val(s4_fm_reg >>> s4_fsh_reg);
    assign out_second_next = sat_val(s4_gm_reg >>> s4_gsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_f_reg       <= f_op;
            s1_g_reg       <= g_op;
            s1_c_reg       <= f_c;
            s1_use_c_reg   <= f_use_c;
            s1_tag_reg     <= tag_next;

            s2_fp_reg      <= s2_fp_next;
            s2_gp_reg      <= s2_gp_next;
            s2_c_reg       <= s1_c_reg;
            s2_use_c_reg   <= s1_use_c_reg;
            s2_fctl_reg    <= ctl_of(s1_f_reg);
            s2_gctl_reg    <= ctl_of(s1_g_reg);
            s2_tag_reg     <= s1_tag_reg;

            s3_fp_reg      <= s3_fp_next;
            s3_gp_reg      <= s3_gp_next;
            s3_fctl_reg    <= s2_fctl_reg;
            s3_gctl_reg    <= s2_gctl_reg;
            s3_tag_reg     <= s2_tag_reg;

            s4_fm_reg      <= s4_fm_next;
            s4_gm_reg      <= s4_gm_next;
            s4_fsh_reg     <= s3_fctl_reg.sh;
            s4_gsh_reg     <= s3_gctl_reg.sh;
            s4_tag_reg     <= s3_tag_reg;

            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_tag_reg    <= s4_tag_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_node_index   = out_tag_reg.node;
    assign m_last_node    = out_tag_reg.last;
    assign m_first_value  = out_first_reg;
    assign m_second_value = out_second_reg;

endmodule
`default_nettype wire

@@ rtl/quad_shape_function_eval_unit.sv @@
// Top level of the Q4/Q8 quadrilateral shape function evaluator.
`default_nettype none
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    xi_coord, eta_coord, command
//  m_        out        m_valid/m_ready    node_index, first_value, second_value, last_node
//  cfg_      in         cfg_wr_en          cfg_wr_data -> node_count (reset 4)
//
//  One result word per node leaves per cycle while m_ready does not stall:
//  an item yields 4 words for the bilinear element, 8 for serendipity,
//  min(node_count, 8) for other node counts, and none when node_count is zero.
//  After an input word is taken into the queue, its first result word passes
//  the registers for operand select, two multiplier stages, rounding, saturation.
//  A two-entry item queue lets the input side keep accepting while the
//  output stalls; a stall on m_ready freezes the whole evaluation pipeline.
//  Synchronous active-low reset empties queue and pipeline, node_count = 4.
//
module quad_shape_function_eval_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [qsfe_pkg::COORD_W-1:0] s_xi_coord,
    input  wire logic signed [qsfe_pkg::COORD_W-1:0] s_eta_coord,
    input  wire logic                                s_command,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [qsfe_pkg::NODE_W-1:0]              m_node_index,
    output logic signed [qsfe_pkg::VAL_W-1:0]        m_first_value,
    output logic signed [qsfe_pkg::VAL_W-1:0]        m_second_value,
    output logic                                     m_last_node,

    input  wire logic                                cfg_wr_en,
    input  wire logic [qsfe_pkg::NC_W-1:0]           cfg_wr_data
);
    import qsfe_pkg::*;

    logic [NC_W-1:0] node_count_reg, node_count_next;
    item_t           front_item;
    item_t           head_item;
    logic            q_full;
    logic            head_valid;
    logic            q_pop;

    // node count register; user must write it only while the unit is idle; not enforced
    assign node_count_next = cfg_wr_en ? cfg_wr_data : node_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NC_RESET;
        end else begin
            node_count_reg <= node_count_next;
        end
    end

    // front: classify the word and form the quadratic terms
    qsfe_front u_front (
        .node_count (node_count_reg),
        .xi_coord   (s_xi_coord),
        .eta_coord  (s_eta_coord),
        .command    (s_command),
        .item       (front_item)
    );

    assign s_ready = !q_full;

    qsfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_item  (front_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_item  (head_item),
        .head_valid (head_valid)
    );

    // back: one node per cycle unless m_ready stalls, through the multiply / round pipeline
    qsfe_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_item      (head_item),
        .head_valid     (head_valid),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node_index   (m_node_index),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value),
        .m_last_node    (m_last_node)
    );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the Q4/Q8 quadrilateral shape function evaluator.
`default_nettype none
module testbench;
    import qsfe_pkg::*;

    // Product shift: three Q2.14 factors and the quarter weight of the formulas.
    localparam int     RND_SHIFT      = 2 * FRAC_BITS + 2;
    localparam longint S_ONE          = longint'(1) << FRAC_BITS;
    // Idle cycles before a node_count write; covers items with no result word.
    localparam int     DRAIN_CYCLES   = 24;
    // Long receiver hold-off, so the item queue fills and s_ready drops.
    localparam int     HOLD_CYCLES    = 200;
    // Cycles with no handshake on either side before the run is called hung.
    localparam int     WATCHDOG_LIMIT = 2000;

    // One expected result word.
    typedef struct {
        logic [NODE_W-1:0]       node;
        logic signed [VAL_W-1:0] first;
        logic signed [VAL_W-1:0] second;
        logic                    last;
    } node_word_t;

    // Predicts the node words of each accepted input word and checks outputs in order.
    class node_result_board;
        node_word_t      expected_nodes[$];
        logic [NC_W-1:0] node_count;
        int              errors;
        int              results_checked;

        function new();
            node_count      = NC_RESET;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void load_node_count(logic [NC_W-1:0] nc);
            node_count = nc;
        endfunction

        function int pending();
            return expected_nodes.size();
        endfunction

        // k*a*b*c / 2^RND_SHIFT, round half up, saturate to 16 bits
        function logic signed [VAL_W-1:0] round_sat(longint k, longint a, longint b, longint c);
            logic signed [127:0] wk, wa, wb, wc, prod;
            wk = k;
            wa = a;
            wb = b;
            wc = c;
            prod = wk * wa * wb * wc + (128'sd1 <<< (RND_SHIFT - 1));
            prod = prod >>> RND_SHIFT;
            if (prod > 128'sd32767)
                return 16'sh7fff;
            else if (prod < -128'sd32768)
                return 16'sh8000;
            return prod[VAL_W-1:0];
        endfunction

        function void note_word(logic signed [COORD_W-1:0] xi, logic signed [COORD_W-1:0] eta,
                                logic cmd);
            longint                  x, y, xm, xp, ym, yp, cx, cy;
            logic signed [VAL_W-1:0] f [MAX_NODES];
            logic signed [VAL_W-1:0] g [MAX_NODES];
            int                      count;
            node_word_t              w;
            x  = xi;
            y  = eta;
            xm = S_ONE - x;
            xp = S_ONE + x;
            ym = S_ONE - y;
            yp = S_ONE + y;
            cx = S_ONE * S_ONE - x * x;
            cy = S_ONE * S_ONE - y * y;
            for (int i = 0; i < MAX_NODES; i++) begin
                f[i] = '0;
                g[i] = '0;
            end
            if (node_count == NC_BILIN) begin
                count = 4;
                if (cmd == CMD_VALUE) begin
                    f[0] = round_sat(1, S_ONE, xm, ym);
                    f[1] = round_sat(1, S_ONE, xp, ym);
                    f[2] = round_sat(1, S_ONE, xp, yp);
                    f[3] = round_sat(1, S_ONE, xm, yp);
                end else begin
                    f[0] = round_sat(-1, S_ONE, S_ONE, ym);
                    f[1] = round_sat(1, S_ONE, S_ONE, ym);
                    f[2] = round_sat(1, S_ONE, S_ONE, yp);
                    f[3] = round_sat(-1, S_ONE, S_ONE, yp);
                    g[0] = round_sat(-1, S_ONE, S_ONE, xm);
                    g[1] = round_sat(-1, S_ONE, S_ONE, xp);
                    g[2] = round_sat(1, S_ONE, S_ONE, xp);
                    g[3] = round_sat(1, S_ONE, S_ONE, xm);
                end
            end else if (node_count == NC_SEREN) begin
                count = 8;
                if (cmd == CMD_VALUE) begin
                    f[0] = round_sat(1, xm, ym, -x - y - S_ONE);
                    f[1] = round_sat(1, xp, ym, x - y - S_ONE);
                    f[2] = round_sat(1, xp, yp, x + y - S_ONE);
                    f[3] = round_sat(1, xm, yp, y - x - S_ONE);
                    f[4] = round_sat(2, 1, cx, ym);
                    f[5] = round_sat(2, 1, cy, xp);
                    f[6] = round_sat(2, 1, cx, yp);
                    f[7] = round_sat(2, 1, cy, xm);
                end else begin
                    f[0] = round_sat(1, S_ONE, ym, 2 * x + y);
                    f[1] = round_sat(1, S_ONE, ym, 2 * x - y);
                    f[2] = round_sat(1, S_ONE, yp, 2 * x + y);
                    f[3] = round_sat(1, S_ONE, yp, 2 * x - y);
                    f[4] = round_sat(-4, S_ONE, x, ym);
                    f[5] = round_sat(2, S_ONE, 1, cy);
                    f[6] = round_sat(-4, S_ONE, x, yp);
                    f[7] = round_sat(-2, S_ONE, 1, cy);
                    g[0] = round_sat(1, S_ONE, xm, x + 2 * y);
                    g[1] = round_sat(1, S_ONE, xp, 2 * y - x);
                    g[2] = round_sat(1, S_ONE, xp, x + 2 * y);
                    g[3] = round_sat(1, S_ONE, xm, 2 * y - x);
                    g[4] = round_sat(-2, S_ONE, 1, cx);
                    g[5] = round_sat(-4, S_ONE, y, xp);
                    g[6] = round_sat(2, S_ONE, 1, cx);
                    g[7] = round_sat(-4, S_ONE, y, xm);
                end
            end else begin
                // unsupported count: zero words, capped at eight, none for zero
                count = (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
            end
            for (int n = 0; n < count; n++) begin
                w.node   = NODE_W'(n);
                w.first  = f[n];
                w.second = g[n];
                w.last   = (n == count - 1);
                expected_nodes.push_back(w);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH: %0s", what);
        endtask

        task check_word(logic [NODE_W-1:0] node, logic signed [VAL_W-1:0] first,
                        logic signed [VAL_W-1:0] second, logic last);
            node_word_t e;
            if (expected_nodes.size() == 0) begin
                report_mismatch($sformatf("unexpected word node=%0d first=%0d second=%0d",
                                          node, first, second));
                return;
            end
            e = expected_nodes.pop_front();
            results_checked++;
            if (node !== e.node)
                report_mismatch($sformatf("node_index got %0d exp %0d", node, e.node));
            if (first !== e.first)
                report_mismatch($sformatf("first_value node %0d got %0d exp %0d",
                                          e.node, first, e.first));
            if (second !== e.second)
                report_mismatch($sformatf("second_value node %0d got %0d exp %0d",
                                          e.node, second, e.second));
            if (last !== e.last)
                report_mismatch($sformatf("last_node node %0d got %0b exp %0b",
                                          e.node, last, e.last));
        endtask
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_xi_coord = '0;
    logic signed [COORD_W-1:0] s_eta_coord = '0;
    logic                      s_command = CMD_VALUE;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [NODE_W-1:0]         m_node_index;
    logic signed [VAL_W-1:0]   m_first_value;
    logic signed [VAL_W-1:0]   m_second_value;
    logic                      m_last_node;
    logic                      cfg_wr_en = 1'b0;
    logic [NC_W-1:0]           cfg_wr_data = '0;

    node_result_board board;
    bit               calm = 1'b0;      // no idling on either side
    bit               hold_req = 1'b0;  // ask the receiver for one long hold-off
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int               words_sent = 0;
    int               settings_run = 0;

    quad_shape_function_eval_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_xi_coord     (s_xi_coord),
        .s_eta_coord    (s_eta_coord),
        .s_command      (s_command),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_node_index   (m_node_index),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value),
        .m_last_node    (m_last_node),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    // 12-unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: random stall bursts, plus the one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Output monitor: every accepted word goes against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_word(m_node_index, m_first_value, m_second_value, m_last_node);
    end

    // Watchdog on handshake activity.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d words still expected",
                         quiet_cycles, board.pending());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Mostly in-range coordinates; some corners, some anywhere in 16 bits.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return COORD_W'($urandom());
        if (r == 1) begin
            case ($urandom_range(0, 2))
                0:       return -16'sd16384;
                1:       return 16'sd0;
                default: return 16'sd16384;
            endcase
        end
        return COORD_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // Offer one input word; returns at the falling edge after it is taken.
    task automatic send_word(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y, input logic cmd);
        int   gap;
        logic taken;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_xi_coord  <= x;
        s_eta_coord <= y;
        s_command   <= cmd;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_ready;
        end
        board.note_word(x, y, cmd);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input int n);
        repeat (n)
            send_word(rand_coord(), rand_coord(),
                      ($urandom_range(0, 1) == 1) ? CMD_DERIV : CMD_VALUE);
    endtask

    // Corners, center, out-of-range saturation and an odd interior point, both commands.
    task automatic send_directed();
        logic signed [COORD_W-1:0] dx [6];
        logic signed [COORD_W-1:0] dy [6];
        dx = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd0, -16'sd32768, 16'sd12345};
        dy = '{-16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 16'sd32767, -16'sd5461};
        for (int i = 0; i < 6; i++) begin
            send_word(dx[i], dy[i], CMD_VALUE);
            send_word(dx[i], dy[i], CMD_DERIV);
        end
    endtask

    // node_count is only changed with the block empty.
    task automatic write_node_count(input logic [NC_W-1:0] nc);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= nc;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.load_node_count(nc);
        settings_run++;
    endtask

    initial begin
        board = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        write_node_count(NC_SEREN);
        send_directed();
        write_node_count(NC_BILIN);
        send_directed();

        // unsupported counts: none, capped at eight, a single word
        write_node_count(4'd0);
        send_random(15);
        write_node_count(4'd15);
        send_random(15);
        write_node_count(4'd1);
        send_random(15);

        // serendipity with the long output hold-off; input must back up
        write_node_count(NC_SEREN);
        hold_req = 1'b1;
        send_random(70);

        write_node_count(NC_BILIN);
        send_random(40);
        write_node_count(4'd7);
        send_random(12);
        write_node_count(4'd9);
        send_random(10);

        // full-rate stretch at the end
        write_node_count(NC_SEREN);
        calm = 1'b1;
        send_random(40);
        s_valid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input words and %0d node words over %0d node_count settings,",
                 words_sent, board.results_checked, settings_run);
        $display("with random stalls, a long output hold-off and a full-rate tail.");
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
